// ----- src/tensor_repeat_gather_offset_unit_defines.svh -----
// Assertion macros shared by the repeat gather offset unit.
`ifndef TENSOR_REPEAT_GATHER_OFFSET_UNIT_DEFINES_SVH
`define TENSOR_REPEAT_GATHER_OFFSET_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TRGO_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TRGO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- src/trgo_pkg.sv -----
// Constants shared by the repeat gather offset unit.
package trgo_pkg;
  localparam int DEF_MAX_DIMS = 4;
  localparam int NUM_REGS     = 4;
  localparam int WORD_W       = 56;
  localparam int INDEX_W      = 48;
  localparam int OFFSET_W     = 42;
  localparam int DIGIT_W      = 16;
  localparam int SSTRIDE_W    = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int TOTAL_W      = INDEX_W + 1;
  localparam logic [WORD_W-1:0] DIM_RESET = 56'd65537;
endpackage

// ----- src/tensor_repeat_gather_offset_unit.sv -----
// Repeat gather offset unit: flat target index to source element offset.
// Stages: entry range check, restoring-division stages, multiply stage, sum and result register.
// Throughput: one beat per cycle unless busy; division takes one quotient bit a stage.
// A configuration write restarts a shift-add sequencer that rebuilds the target strides;
// busy stays high after the last write until the strides and the total are rebuilt.
// Synchronous reset restores unit padding dims and needs no rebuild; results cannot be stalled.
`include "tensor_repeat_gather_offset_unit_defines.svh"

module tensor_repeat_gather_offset_unit #(
  parameter int MAX_DIMS = trgo_pkg::DEF_MAX_DIMS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [trgo_pkg::INDEX_W-1:0]   flat_index,
  output logic                           done,
  output logic [trgo_pkg::OFFSET_W-1:0]  source_offset,
  output logic                           in_range,
  output logic                           size_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [trgo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trgo_pkg::WORD_W-1:0]    cfg_data
);

  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DGW = trgo_pkg::DIGIT_W;
  localparam int IW  = trgo_pkg::INDEX_W;
  localparam int TW  = trgo_pkg::TOTAL_W;
  localparam int NST = 2 * MAX_DIMS * DGW;
  localparam int PW  = DGW + trgo_pkg::SSTRIDE_W;

  localparam logic SEQ_IDLE = 1'b0;
  localparam logic SEQ_MUL  = 1'b1;

  localparam logic [TW-1:0] LIMIT = TW'(1) << IW;

  // Configuration registers and derived strides.
  logic [trgo_pkg::WORD_W-1:0] dim_word [MAX_DIMS];
  logic [IW-1:0] stride_lo [MAX_DIMS];
  logic [IW-1:0] stride_hi [MAX_DIMS];
  logic [TW-1:0] total;

  // Stride sequencer.
  logic            state;
  logic [DW-1:0]   dcnt;
  logic            phase;
  logic [3:0]      bcnt;
  logic [TW-1:0]   acc;
  logic [TW-1:0]   prod;
  logic [TW:0]     prod_sum;
  logic [TW-1:0]   prod_next;
  logic [DGW-1:0]  mul_word;
  logic            mbit;
  logic            cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign busy      = (state == SEQ_MUL);

  // One multiplier bit per cycle, saturating at 2^48.
  always_comb begin
    mul_word  = phase ? dim_word[dcnt][31:16] : dim_word[dcnt][15:0];
    mbit      = mul_word[bcnt];
    prod_sum  = {prod, 1'b0} + (mbit ? {1'b0, acc} : '0);
    prod_next = (prod_sum >= {1'b0, LIMIT}) ? LIMIT : prod_sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      dcnt  <= '0;
      phase <= 1'b0;
      bcnt  <= '0;
      acc   <= TW'(1);
      prod  <= '0;
      total <= TW'(1);
      for (int i = 0; i < MAX_DIMS; i++) begin
        dim_word[i]  <= trgo_pkg::DIM_RESET;
        stride_lo[i] <= IW'(1);
        stride_hi[i] <= IW'(1);
      end
    end else if (cfg_fire) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (i < trgo_pkg::NUM_REGS && cfg_index == trgo_pkg::CFG_IDX_W'(i)) begin
          dim_word[i] <= cfg_data;
        end
      end
      state <= SEQ_MUL;
      dcnt  <= DW'(MAX_DIMS - 1);
      phase <= 1'b0;
      bcnt  <= 4'd15;
      acc   <= TW'(1);
      prod  <= '0;
    end else if (state == SEQ_MUL) begin
      if (!phase) begin
        stride_lo[dcnt] <= acc[IW-1:0];
      end
      if (bcnt == 4'd0) begin
        prod <= '0;
        bcnt <= 4'd15;
        acc  <= prod_next;
        if (!phase) begin
          stride_hi[dcnt] <= prod_next[IW-1:0];
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          if (dcnt == '0) begin
            total <= prod_next;
            state <= SEQ_IDLE;
          end else begin
            dcnt <= dcnt - DW'(1);
          end
        end
      end else begin
        prod <= prod_next;
        bcnt <= bcnt - 4'd1;
      end
    end
  end

  // Division pipeline: rem, lo digits and flags travel with the valid bit.
  logic                          vld  [0:NST];
  logic                          inr  [0:NST];
  logic                          ovf  [0:NST];
  logic [IW-1:0]                 rem  [0:NST];
  logic [MAX_DIMS-1:0][DGW-1:0]  dig  [0:NST];

  // Entry stage: range check against the element total.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
    rem[0] <= flat_index;
    dig[0] <= '0;
    ovf[0] <= total[IW];
    inr[0] <= !total[IW] && ({1'b0, flat_index} < total);
  end

  // One quotient bit per stage; digits run outer to inner, repeat digit first.
  for (genvar s = 0; s < NST; s++) begin : g_div
    localparam int D   = s / DGW;
    localparam int K   = DGW - 1 - (s % DGW);
    localparam int DIM = D / 2;
    localparam bit HI  = ((D % 2) == 0);
    logic [IW+DGW-1:0]            sh;
    logic                         ge;
    logic [MAX_DIMS-1:0][DGW-1:0] dig_next;
    always_comb begin
      sh = {{DGW{1'b0}}, (HI ? stride_hi[DIM] : stride_lo[DIM])} << K;
      ge = {{DGW{1'b0}}, rem[s]} >= sh;
      dig_next = dig[s];
      if (!HI) begin
        dig_next[DIM][K] = ge;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      inr[s+1] <= inr[s];
      ovf[s+1] <= ovf[s];
      rem[s+1] <= ge ? (rem[s] - sh[IW-1:0]) : rem[s];
      dig[s+1] <= dig_next;
    end
  end

  // Multiply stage: each source coordinate times its source stride.
  logic                 m_vld;
  logic                 m_inr;
  logic                 m_ovf;
  logic [PW-1:0]        m_prod [MAX_DIMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= vld[NST];
    end
    m_inr <= inr[NST];
    m_ovf <= ovf[NST];
    for (int i = 0; i < MAX_DIMS; i++) begin
      m_prod[i] <= dig[NST][i] * dim_word[i][55:32];
    end
  end

  // Sum stage and result register.
  logic [trgo_pkg::OFFSET_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sum = sum + trgo_pkg::OFFSET_W'(m_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    source_offset <= m_inr ? sum : '0;
    in_range      <= m_inr;
    size_overflow <= m_ovf;
  end

  // Checks.
  `TRGO_ASSERT_IMPL(a_ovf_not_in_range, clk, rst, done && size_overflow, !in_range)
  `TRGO_ASSERT_IMPL(a_out_of_range_zero, clk, rst, done && !in_range, source_offset == '0)
  `TRGO_ASSERT_NEXT(a_cfg_sets_busy, clk, rst, cfg_fire, busy)
  `TRGO_ASSERT_NEXT(a_no_entry_when_busy, clk, rst, busy, !vld[0])

endmodule

// ----- tb/tb_tensor_repeat_gather_offset_unit.sv -----
// Self-checking testbench for the repeat gather offset unit.
`timescale 1ns / 1ps

module tb_tensor_repeat_gather_offset_unit;
  import trgo_pkg::*;

  localparam int DIMS = DEF_MAX_DIMS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 140;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 215;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
  localparam longint unsigned TOTAL_CAP = 64'h0001_0000_0000_0000;

  // Register indexes; anything at or above NUM_REGS is dropped by the block.
  localparam logic [CFG_IDX_W-1:0] REG_DIM0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                in_rng;
    logic                ovf;
  } gather_res_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [WORD_W-1:0]    word;
    logic [INDEX_W-1:0]   index;
    bit                   typed;
    gather_res_t          want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [INDEX_W-1:0]   flat_index;
  logic                 done;
  logic [OFFSET_W-1:0]  source_offset;
  logic                 in_range;
  logic                 size_overflow;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  logic [WORD_W-1:0] dim_cfg [DIMS];
  gather_res_t       pending_offsets[$];
  stim_row_t         stim_rows[$];
  int                errors;
  int                results_seen;
  int                items_sent;
  int                cycles;
  int                gap_pct;

  tensor_repeat_gather_offset_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .flat_index(flat_index),
    .done(done), .source_offset(source_offset), .in_range(in_range),
    .size_overflow(size_overflow), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] dim_word(input int ext, input int rep,
                                                 input logic [SSTRIDE_W-1:0] stride);
    return {stride, rep[DIGIT_W-1:0], ext[DIGIT_W-1:0]};
  endfunction

  // Target element total under the current dims, with the zero and overflow cases.
  function automatic longint unsigned target_total(output bit zero, output bit over);
    longint unsigned total;
    longint unsigned tgt;
    total = 1;
    zero = 1'b0;
    over = 1'b0;
    for (int i = 0; i < DIMS; i++) begin
      if (dim_cfg[i][15:0] == 0 || dim_cfg[i][31:16] == 0) zero = 1'b1;
    end
    if (!zero) begin
      for (int i = 0; i < DIMS; i++) begin
        tgt = longint'(dim_cfg[i][15:0]) * longint'(dim_cfg[i][31:16]);
        if (total > (TOTAL_CAP - 1) / tgt) begin
          over = 1'b1;
          break;
        end
        total = total * tgt;
      end
    end
    return zero ? 0 : total;
  endfunction

  // Splits the flat index along the row-major target strides and sums the
  // wrapped source coordinates times their strides.
  function automatic gather_res_t predict_gather(input logic [INDEX_W-1:0] idx);
    gather_res_t r;
    longint unsigned total;
    longint unsigned tstride [DIMS];
    longint unsigned rem;
    longint unsigned off;
    longint unsigned coord;
    bit zero;
    bit over;
    total = target_total(zero, over);
    r = '0;
    r.ovf = over;
    if (zero || over || longint'(idx) >= total) return r;
    tstride[DIMS-1] = 1;
    for (int i = DIMS - 2; i >= 0; i--)
      tstride[i] = tstride[i+1] * longint'(dim_cfg[i+1][15:0]) * longint'(dim_cfg[i+1][31:16]);
    rem = idx;
    off = 0;
    for (int i = 0; i < DIMS; i++) begin
      coord = rem / tstride[i];
      rem = rem % tstride[i];
      off += (coord % longint'(dim_cfg[i][15:0])) * longint'(dim_cfg[i][55:32]);
    end
    r.offset = off[OFFSET_W-1:0];
    r.in_rng = 1'b1;
    return r;
  endfunction

  // Mostly small tiles with random strides, some unit, huge or fully random dims.
  function automatic logic [WORD_W-1:0] rand_dim_word();
    case ($urandom_range(9))
      0: return DIM_RESET;
      1: return WORD_W'({$urandom, $urandom});
      2: return dim_word($urandom_range(65535, 1), $urandom_range(255, 1),
                         SSTRIDE_W'($urandom));
      default: return dim_word($urandom_range(6, 1), $urandom_range(4, 1),
                               SSTRIDE_W'($urandom));
    endcase
  endfunction

  // Mostly indexes inside the target, the rest anywhere in the 48-bit space.
  function automatic logic [INDEX_W-1:0] rand_flat_index();
    longint unsigned total;
    longint unsigned raw;
    bit zero;
    bit over;
    total = target_total(zero, over);
    raw = {$urandom, $urandom};
    if (!zero && !over && $urandom_range(9) < 8) return INDEX_W'(raw % total);
    return raw[INDEX_W-1:0];
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] r, input logic [WORD_W-1:0] w);
    stim_row_t row;
    row = '{ROW_CFG, r, w, '0, 1'b0, '0};
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic add_item(input logic [INDEX_W-1:0] idx, input bit typed,
                          input gather_res_t want);
    stim_row_t row;
    row = '{ROW_ITEM, '0, '0, idx, typed, want};
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [WORD_W-1:0] w);
    start <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    if (r < NUM_REGS && r < DIMS) dim_cfg[r] = w;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Start stays high between back-to-back beats.
  task automatic send_index(input logic [INDEX_W-1:0] idx, input bit typed,
                            input gather_res_t want);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    flat_index <= idx;
    do @(posedge clk); while (busy);
    pending_offsets.insert(pending_offsets.size(), typed ? want : predict_gather(idx));
    items_sent++;
  endtask

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    gather_res_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (pending_offsets.size() == 0) begin
        $display("%0t: unexpected result offset=%h in_range=%b size_overflow=%b",
                 $time, source_offset, in_range, size_overflow);
        errors++;
      end else begin
        exp_r = pending_offsets.pop_front();
        if (source_offset !== exp_r.offset) begin
          $display("%0t: source_offset expected %h actual %h", $time, exp_r.offset,
                   source_offset);
          errors++;
        end
        if (in_range !== exp_r.in_rng) begin
          $display("%0t: in_range expected %b actual %b", $time, exp_r.in_rng, in_range);
          errors++;
        end
        if (size_overflow !== exp_r.ovf) begin
          $display("%0t: size_overflow expected %b actual %b", $time, exp_r.ovf,
                   size_overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               pending_offsets.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic [WORD_W-1:0] huge;
    int pct_modes [3];
    int small_idx [9];
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    cycles = 0;
    gap_pct = 0;
    pct_modes = '{0, 78, 19};
    small_idx = '{0, 1, 5, 11, 12, 37, 143, 287, 288};
    for (int i = 0; i < DIMS; i++) dim_cfg[i] = DIM_RESET;
    rst = 1'b1;
    start = 1'b0;
    flat_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset dims, overflow, zero repeat, a small tile, maximum sizes.
    huge = dim_word(65535, 65535, 0);
    add_item(0, 1, '{0, 1'b1, 1'b0});
    add_item(1, 1, '{0, 1'b0, 1'b0});
    add_item(INDEX_MAX, 1, '{0, 1'b0, 1'b0});
    add_cfg(REG_DIM0, huge);
    add_cfg(REG_DIM1, huge);
    add_cfg(REG_DIM2, huge);
    add_cfg(REG_DIM3, huge);
    add_item(0, 1, '{0, 1'b0, 1'b1});
    add_item(INDEX_MAX, 1, '{0, 1'b0, 1'b1});
    // A zero repeat wins over the overflow of the other dims.
    add_cfg(REG_DIM3, dim_word(65535, 0, 0));
    add_item(0, 1, '{0, 1'b0, 1'b0});
    add_cfg(REG_DIM0, DIM_RESET);
    add_cfg(REG_DIM1, dim_word(2, 2, 5));
    add_cfg(REG_DIM2, dim_word(3, 2, 7));
    add_cfg(REG_DIM3, dim_word(4, 3, 1));
    foreach (small_idx[k])
      add_item(INDEX_W'(small_idx[k]), 0, '0);
    // A write past the last register must leave the dims alone.
    add_cfg(REG_UNUSED, {WORD_W{1'b1}});
    add_item(287, 0, '0);
    // Near the 2^48 total with maximum strides.
    add_cfg(REG_DIM1, dim_word(65535, 1, 24'hFFFFFF));
    add_cfg(REG_DIM2, dim_word(65535, 1, 24'hFFFFFF));
    add_cfg(REG_DIM3, dim_word(65535, 1, 24'hFFFFFF));
    add_item(48'hFFFD_0002_FFFE, 0, '0);
    add_item(48'hFFFD_0002_FFFF, 0, '0);
    add_item(48'h1234_5678_9ABC, 0, '0);

    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      if (row.kind == ROW_CFG) write_reg(row.reg_idx, row.word);
      else send_index(row.index, row.typed, row.want);
    end

    // Random part: each phase reprograms every dim, then streams indexes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_pct = pct_modes[p % 3];
      write_reg(REG_DIM0, rand_dim_word());
      write_reg(REG_DIM1, rand_dim_word());
      write_reg(REG_DIM2, rand_dim_word());
      write_reg(REG_DIM3, rand_dim_word());
      if ($urandom_range(2) == 0)
        write_reg(3'(NUM_REGS + $urandom_range(3)), WORD_W'({$urandom, $urandom}));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_index(rand_flat_index(), 0, '0);
    end
    start <= 1'b0;

    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d index beats and %0d results over %0d random dim settings.",
             items_sent, results_seen, RANDOM_PHASES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/trgo_pkg.sv
src/tensor_repeat_gather_offset_unit.sv
tb/tb_tensor_repeat_gather_offset_unit.sv
